@@ rtl/core/rational_add_reduce_core_assert.svh @@
`ifndef RATIONAL_ADD_REDUCE_CORE_ASSERT_SVH
`define RATIONAL_ADD_REDUCE_CORE_ASSERT_SVH

// same-cycle implication, checked on clock, off during reset
`define RAR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off during reset
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rar_pkg.sv @@
`timescale 1ns / 1ps

package rar_pkg;

   localparam int unsigned NumInWidth  = 16;
   localparam int unsigned DenInWidth  = 15;
   localparam int unsigned SumNumWidth = 32;
   localparam int unsigned SumDenWidth = 30;
   localparam int unsigned MagWidth    = 31;
   localparam int unsigned DivCntWidth = $clog2(MagWidth);

   typedef enum logic [1:0] {
      DIV_GCD = 2'd0,
      DIV_NUM = 2'd1,
      DIV_DEN = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      logic        sum_en;
      logic        order_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        gcd_step;
      logic        q_num_en;
      logic        q_den_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic sum_zero;
      logic div_done;
      logic rem_zero;
   } stat_type;

endpackage

@@ rtl/core/rar_divider.sv @@
`timescale 1ns / 1ps

module rar_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rar_pkg::MagWidth-1:0] dividend,
   input  logic [rar_pkg::MagWidth-1:0] divisor,
   output logic                         done,
   output logic [rar_pkg::MagWidth-1:0] quotient,
   output logic [rar_pkg::MagWidth-1:0] remainder
);

   localparam int unsigned W = rar_pkg::MagWidth;

   logic                               busy_ff;
   logic                               done_ff;
   logic [rar_pkg::DivCntWidth-1:0]    count_ff;
   logic [W-1:0]                       rem_ff;
   logic [W-1:0]                       quo_ff;

   logic [W:0]                         shifted;
   logic [W:0]                         diff;
   logic                               fits;
   logic [W-1:0]                       rem_in;
   logic [W-1:0]                       quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_in  = {quo_ff[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == rar_pkg::DivCntWidth'(W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= '0;
         rem_ff   <= '0;
         quo_ff   <= dividend;
      end else if (busy_ff) begin
         count_ff <= count_ff + rar_pkg::DivCntWidth'(1);
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/rar_datapath.sv @@
`timescale 1ns / 1ps

module rar_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [rar_pkg::NumInWidth-1:0]  num_first,
   input  logic        [rar_pkg::DenInWidth-1:0]  den_first,
   input  logic signed [rar_pkg::NumInWidth-1:0]  num_second,
   input  logic        [rar_pkg::DenInWidth-1:0]  den_second,
   input  rar_pkg::cmd_type                       cmd,
   output rar_pkg::stat_type                      stat,
   output logic signed [rar_pkg::SumNumWidth-1:0] sum_num,
   output logic        [rar_pkg::SumDenWidth-1:0] sum_den,
   output logic                                   status
);

   localparam int unsigned W = rar_pkg::MagWidth;

   logic signed [rar_pkg::NumInWidth-1:0]  n1_ff, n2_ff;
   logic        [rar_pkg::DenInWidth-1:0]  d1_ff, d2_ff;
   logic signed [rar_pkg::SumNumWidth-1:0] p1_ff, p2_ff;
   logic        [rar_pkg::SumDenWidth-1:0] den_ff;
   logic signed [rar_pkg::SumNumWidth-1:0] sum_ff;
   logic        [W-1:0]                    big_ff, small_ff;
   logic        [W-1:0]                    qnum_ff;
   logic        [rar_pkg::SumDenWidth-1:0] qden_ff;
   logic signed [rar_pkg::SumNumWidth-1:0] sum_num_ff;
   logic        [rar_pkg::SumDenWidth-1:0] sum_den_ff;
   logic                                   status_ff;

   logic signed [rar_pkg::SumNumWidth-1:0] p1_in, p2_in;
   logic signed [rar_pkg::SumNumWidth-1:0] neg_sum;
   logic        [W-1:0]                    mag;
   logic        [W-1:0]                    den_ext;
   logic        [W-1:0]                    dividend;
   logic                                   div_done;
   logic        [W-1:0]                    div_quo, div_rem;
   logic signed [rar_pkg::SumNumWidth-1:0] num_in;
   logic        [rar_pkg::SumDenWidth-1:0] den_in;
   logic                                   status_in;
   logic                                   den_zero, sum_zero;

   assign p1_in   = rar_pkg::SumNumWidth'(n1_ff)
                    * rar_pkg::SumNumWidth'($signed({1'b0, d2_ff}));
   assign p2_in   = rar_pkg::SumNumWidth'(n2_ff)
                    * rar_pkg::SumNumWidth'($signed({1'b0, d1_ff}));
   assign neg_sum = -sum_ff;
   assign mag     = sum_ff[rar_pkg::SumNumWidth-1] ? neg_sum[W-1:0] : sum_ff[W-1:0];
   assign den_ext = {{(W - rar_pkg::SumDenWidth){1'b0}}, den_ff};

   assign den_zero = (d1_ff == '0) || (d2_ff == '0);
   assign sum_zero = (sum_ff == '0);

   always_comb begin
      case (cmd.div_sel)
         rar_pkg::DIV_GCD: dividend = big_ff;
         rar_pkg::DIV_NUM: dividend = mag;
         rar_pkg::DIV_DEN: dividend = den_ext;
         default:          dividend = big_ff;
      endcase
   end

   rar_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (small_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         n1_ff <= num_first;
         d1_ff <= den_first;
         n2_ff <= num_second;
         d2_ff <= den_second;
      end
      if (cmd.mul_en) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         den_ff <= rar_pkg::SumDenWidth'(d1_ff) * rar_pkg::SumDenWidth'(d2_ff);
      end
      if (cmd.sum_en) begin
         sum_ff <= p1_ff + p2_ff;
      end
      if (cmd.order_en) begin
         if (mag >= den_ext) begin
            big_ff   <= mag;
            small_ff <= den_ext;
         end else begin
            big_ff   <= den_ext;
            small_ff <= mag;
         end
      end else if (cmd.gcd_step) begin
         big_ff   <= small_ff;
         small_ff <= div_rem;
      end
      if (cmd.q_num_en) begin
         qnum_ff <= div_quo;
      end
      if (cmd.q_den_en) begin
         qden_ff <= div_quo[rar_pkg::SumDenWidth-1:0];
      end
   end

   always_comb begin
      if (den_zero) begin
         num_in    = '0;
         den_in    = '0;
         status_in = 1'b1;
      end else if (sum_zero) begin
         num_in    = '0;
         den_in    = rar_pkg::SumDenWidth'(1);
         status_in = 1'b0;
      end else begin
         num_in    = sum_ff[rar_pkg::SumNumWidth-1] ? -$signed({1'b0, qnum_ff})
                                                    : $signed({1'b0, qnum_ff});
         den_in    = qden_ff;
         status_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sum_num_ff <= num_in;
         sum_den_ff <= den_in;
         status_ff  <= status_in;
      end
   end

   assign stat.den_zero = den_zero;
   assign stat.sum_zero = sum_zero;
   assign stat.div_done = div_done;
   assign stat.rem_zero = (div_rem == '0);

   assign sum_num = sum_num_ff;
   assign sum_den = sum_den_ff;
   assign status  = status_ff;

endmodule

@@ rtl/core/rar_ctrl.sv @@
`timescale 1ns / 1ps

module rar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rar_pkg::cmd_type  cmd,
   input  rar_pkg::stat_type stat
);

   `include "rational_add_reduce_core_assert.svh"

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL    = 9'b000000010,
      S_SUM    = 9'b000000100,
      S_ORDER  = 9'b000001000,
      S_GSTART = 9'b000010000,
      S_GCD    = 9'b000100000,
      S_DIVN   = 9'b001000000,
      S_DIVD   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.div_sel  = rar_pkg::DIV_GCD;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_ORDER;
         end
         S_ORDER: begin
            if (stat.den_zero || stat.sum_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.order_en = 1'b1;
               state_in     = S_GSTART;
            end
         end
         S_GSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_GCD;
         end
         S_GCD: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = rar_pkg::DIV_NUM;
                  state_in      = S_DIVN;
               end else begin
                  cmd.gcd_step = 1'b1;
                  state_in     = S_GSTART;
               end
            end
         end
         S_DIVN: begin
            if (stat.div_done) begin
               cmd.q_num_en  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = rar_pkg::DIV_DEN;
               state_in      = S_DIVD;
            end
         end
         S_DIVD: begin
            if (stat.div_done) begin
               cmd.q_den_en = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RAR_ASSERT_NOW(a_done_in_wait, stat.div_done,
      (state_ff == S_GCD || state_ff == S_DIVN || state_ff == S_DIVD),
      "divider finished outside a wait state")
   `RAR_ASSERT_NOW(a_no_overwrite, cmd.out_load, (!rsp_valid_ff || rsp_ready),
      "result register loaded over a pending transfer")
   `RAR_ASSERT_NEXT(a_accept_to_mul, req_valid && req_ready, state_ff == S_MUL,
      "accepted transfer did not advance to multiply")
   `RAR_ASSERT_NEXT(a_start_no_done, cmd.div_start, !stat.div_done,
      "divider reported done right after start")

endmodule

@@ rtl/core/rational_add_reduce_core.sv @@
`timescale 1ns / 1ps
// With a zero denominator or sum, S_ORDER goes straight to S_DONE, which loads the result.
// Otherwise S_GSTART/S_GCD loop over Euclid steps, and S_DIVN, S_DIVD divide by the gcd,
// all on one shared 31-bit restoring divider that resolves one quotient bit per cycle.
// Throughput: one item at a time; the next request is taken once the result is registered.
// Reset: synchronous, active high; clears the controller and the result valid flag.
module rational_add_reduce_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rar_pkg::NumInWidth-1:0]  req_num_first,
   input  logic        [rar_pkg::DenInWidth-1:0]  req_den_first,
   input  logic signed [rar_pkg::NumInWidth-1:0]  req_num_second,
   input  logic        [rar_pkg::DenInWidth-1:0]  req_den_second,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rar_pkg::SumNumWidth-1:0] rsp_sum_num,
   output logic        [rar_pkg::SumDenWidth-1:0] rsp_sum_den,
   output logic                                   rsp_status
);

   rar_pkg::cmd_type  cmd;
   rar_pkg::stat_type stat;

   rar_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .num_first  (req_num_first),
      .den_first  (req_den_first),
      .num_second (req_num_second),
      .den_second (req_den_second),
      .cmd        (cmd),
      .stat       (stat),
      .sum_num    (rsp_sum_num),
      .sum_den    (rsp_sum_den),
      .status     (rsp_status)
   );

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CycleLimit = 8_000_000;
   localparam int unsigned DrainCycles = 60;
   localparam int unsigned HoldOffCycles = 2500;

   typedef struct {
      logic signed [rar_pkg::SumNumWidth-1:0] sum_num;
      logic        [rar_pkg::SumDenWidth-1:0] sum_den;
      logic                                   status;
   } sum_result_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [rar_pkg::NumInWidth-1:0]  req_num_first = '0;
   logic        [rar_pkg::DenInWidth-1:0]  req_den_first = '0;
   logic signed [rar_pkg::NumInWidth-1:0]  req_num_second = '0;
   logic        [rar_pkg::DenInWidth-1:0]  req_den_second = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [rar_pkg::SumNumWidth-1:0] rsp_sum_num;
   logic        [rar_pkg::SumDenWidth-1:0] rsp_sum_den;
   logic                                   rsp_status;

   sum_result_type expected_sums[$];
   sum_result_type oldest_sum;
   int             error_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left = 0;
   int unsigned    hold_left = 0;
   bit             no_idle = 1'b0;

   rational_add_reduce_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_num_first  (req_num_first),
      .req_den_first  (req_den_first),
      .req_num_second (req_num_second),
      .req_den_second (req_den_second),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sum_num    (rsp_sum_num),
      .rsp_sum_den    (rsp_sum_den),
      .rsp_status     (rsp_status)
   );

   always #4 clock = ~clock;

   function automatic sum_result_type reduce_fraction_sum(
      input logic signed [rar_pkg::NumInWidth-1:0] n1,
      input logic        [rar_pkg::DenInWidth-1:0] d1,
      input logic signed [rar_pkg::NumInWidth-1:0] n2,
      input logic        [rar_pkg::DenInWidth-1:0] d2
   );
      sum_result_type r;
      longint         num;
      longint         den;
      longint         mag;
      longint         big;
      longint         sml;
      longint         rem;
      longint         q_num;
      longint         q_den;
      r.sum_num = '0;
      r.sum_den = '0;
      r.status  = 1'b0;
      if (d1 == '0 || d2 == '0) begin
         r.status = 1'b1;
         return r;
      end
      num = longint'(n1) * longint'(d2) + longint'(n2) * longint'(d1);
      den = longint'(d1) * longint'(d2);
      if (num == 0) begin
         r.sum_den = rar_pkg::SumDenWidth'(1);
         return r;
      end
      mag = (num < 0) ? -num : num;
      big = (mag > den) ? mag : den;
      sml = (mag > den) ? den : mag;
      rem = big % sml;
      while (rem != 0) begin
         big = sml;
         sml = rem;
         rem = big % sml;
      end
      q_num = num / sml;
      q_den = den / sml;
      r.sum_num = q_num[rar_pkg::SumNumWidth-1:0];
      r.sum_den = q_den[rar_pkg::SumDenWidth-1:0];
      return r;
   endfunction

   task automatic send_fraction(
      input logic signed [rar_pkg::NumInWidth-1:0] n1,
      input logic        [rar_pkg::DenInWidth-1:0] d1,
      input logic signed [rar_pkg::NumInWidth-1:0] n2,
      input logic        [rar_pkg::DenInWidth-1:0] d2
   );
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_num_first  = n1;
      req_den_first  = d1;
      req_num_second = n2;
      req_den_second = d2;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_sums.push_back(reduce_fraction_sum(n1, d1, n2, d2));
      @(negedge clock);
   endtask

   task automatic send_random_fraction();
      logic signed [rar_pkg::NumInWidth-1:0] n1;
      logic signed [rar_pkg::NumInWidth-1:0] n2;
      logic        [rar_pkg::DenInWidth-1:0] d1;
      logic        [rar_pkg::DenInWidth-1:0] d2;
      int unsigned kind;
      int unsigned k;
      kind = $urandom_range(0, 99);
      n1 = rar_pkg::NumInWidth'($urandom_range(0, 65535));
      n2 = rar_pkg::NumInWidth'($urandom_range(0, 65535));
      d1 = rar_pkg::DenInWidth'($urandom_range(1, 32767));
      d2 = rar_pkg::DenInWidth'($urandom_range(1, 32767));
      if (kind < 5) begin
         case ($urandom_range(0, 2))
            0: d1 = '0;
            1: d2 = '0;
            default: begin
               d1 = '0;
               d2 = '0;
            end
         endcase
      end else if (kind < 12) begin
         n2 = -n1;
         d2 = d1;
      end else if (kind < 40) begin
         n1 = rar_pkg::NumInWidth'($signed($urandom_range(0, 400)) - 200);
         n2 = rar_pkg::NumInWidth'($signed($urandom_range(0, 400)) - 200);
         d1 = rar_pkg::DenInWidth'($urandom_range(1, 64));
         d2 = rar_pkg::DenInWidth'($urandom_range(1, 64));
      end else if (kind < 55) begin
         k  = $urandom_range(1, 180);
         d1 = rar_pkg::DenInWidth'(k * $urandom_range(1, 32767 / k));
         d2 = rar_pkg::DenInWidth'(k * $urandom_range(1, 32767 / k));
         n1 = rar_pkg::NumInWidth'(k * ($signed($urandom_range(0, 64)) - 32));
      end
      send_fraction(n1, d1, n2, d2);
   endtask

   task automatic wait_for_drain();
      while (expected_sums.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_corners();
      send_fraction(-16'sd32768, 15'd1, -16'sd32768, 15'd1);
      send_fraction(16'sd32767, 15'd1, 16'sd32767, 15'd1);
      send_fraction(16'sd32767, 15'd32767, 16'sd32767, 15'd32767);
      send_fraction(-16'sd32768, 15'd32767, -16'sd32768, 15'd32767);
      send_fraction(16'sd32767, 15'd32766, -16'sd32768, 15'd32765);
      send_fraction(-16'sd32768, 15'd32767, 16'sd32767, 15'd1);
      send_fraction(16'sd5, 15'd0, 16'sd3, 15'd4);
      send_fraction(16'sd5, 15'd4, 16'sd3, 15'd0);
      send_fraction(16'sd0, 15'd0, 16'sd0, 15'd0);
      send_fraction(-16'sd32768, 15'd0, 16'sd32767, 15'd32767);
      send_fraction(16'sd1, 15'd2, -16'sd1, 15'd2);
      send_fraction(16'sd0, 15'd5, 16'sd0, 15'd7);
      send_fraction(16'sd0, 15'd32767, 16'sd0, 15'd32767);
      send_fraction(-16'sd1, 15'd3, -16'sd1, 15'd6);
      send_fraction(-16'sd7, 15'd12, 16'sd1, 15'd4);
      send_fraction(16'sd1, 15'd1, 16'sd1, 15'd1);
      send_fraction(16'sd0, 15'd1, -16'sd1, 15'd1);
      send_fraction(16'sd17711, 15'd28657, 16'sd10946, 15'd17711);
      send_fraction(16'sd21, 15'd32767, 16'sd13, 15'd32766);
      send_fraction(-16'sd2, 15'd16384, 16'sd3, 15'd8192);
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 800; i++) begin
         no_idle = (i >= 300 && i < 360);
         send_random_fraction();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      for (int i = 0; i < 40; i++) send_random_fraction();
      no_idle = 1'b0;
   endtask

   task automatic test_output_hold_off();
      @(posedge clock);
      hold_left = HoldOffCycles;
      @(negedge clock);
      for (int i = 0; i < 8; i++) send_random_fraction();
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 10; i++) send_random_fraction();
      req_valid = 1'b0;
      wait_for_drain();
      for (int i = 0; i < 10; i++) send_random_fraction();
   endtask

   // drive result-side backpressure
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check each result transfer against the oldest expected sum
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sums.size() == 0) begin
            $error("result transfer with nothing expected: sum_num %0d sum_den %0d status %0d",
                   rsp_sum_num, rsp_sum_den, rsp_status);
            error_count++;
         end else begin
            oldest_sum = expected_sums.pop_front();
            if (rsp_sum_num !== oldest_sum.sum_num) begin
               $error("sum_num: expected %0d, got %0d", oldest_sum.sum_num, rsp_sum_num);
               error_count++;
            end
            if (rsp_sum_den !== oldest_sum.sum_den) begin
               $error("sum_den: expected %0d, got %0d", oldest_sum.sum_den, rsp_sum_den);
               error_count++;
            end
            if (rsp_status !== oldest_sum.status) begin
               $error("status: expected %0d, got %0d", oldest_sum.status, rsp_status);
               error_count++;
            end
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_corners();
      test_random_mix();
      test_back_to_back();
      test_output_hold_off();
      test_pause_until_drained();
      req_valid = 1'b0;
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (expected_sums.size() != 0) begin
         $error("%0d expected sums never arrived", expected_sums.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
